>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Holds the queue geometry, the command and result items and the cell controls.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Queue geometry
  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 16;
  localparam int COUNT_W   = $clog2(DEPTH + 1);

  // Operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // Command item
  typedef struct packed {
    logic        operation;
    logic [15:0] item_value;
    logic [15:0] item_key;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [15:0] out_value;
    logic [15:0] out_key;
    logic        out_valid;
    logic        op_error;
    logic        is_empty;
    logic [4:0]  entry_count;
  } result_t;

  // Per-cycle controls broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the new entry this cycle
    logic ext;  // drop the head and shift toward it
  } cell_ctl_t;

endpackage

>>> hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one key and value, compares against the new key and shifts with its
// neighbors on insert and extract.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic                 occ,
  input  logic                 left_stay,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  logic [15:0]          new_value,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic [15:0]          left_value,
  input  logic [KEY_WIDTH-1:0] right_key,
  input  logic [15:0]          right_value,
  output logic [KEY_WIDTH-1:0] key,
  output logic [15:0]          value,
  output logic                 stay
);

  // Keep the slot when it holds a strictly lower key than the new one
  assign stay = occ && (key < new_key);

  // Take the new entry, the left entry on insert, or the right entry on extract
  always_ff @(posedge clk) begin
    if (ctl.ins && !stay) begin
      key   <= left_stay ? new_key   : left_key;
      value <= left_stay ? new_value : left_value;
    end else if (ctl.ext) begin
      key   <= right_key;
      value <= right_value;
    end
  end

endmodule

>>> hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded min-priority queue kept sorted by key
// A row of slot cells holds the entries in ascending key order, head first.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the item is taken at a clock
//   edge where start is high and busy is low. busy is high only during reset.
//   Insert (OP_INSERT) places item_value ahead of every entry whose key is
//   equal or greater; extract (OP_EXTRACT) removes and returns the head.
//   Result channel: one result item per command, on result while done is
//   high for exactly one cycle, the cycle after the command was taken.
//   The receiver cannot stall; a result must be captured in that cycle.
//   Throughput: one command per cycle while busy is low. Every cell compares
//   its key with the new key and shifts with its neighbors in the same cycle,
//   so the time the slot row takes to settle does not depend on the fill level.
//   An insert into a full queue and an extract from an empty one leave the
//   queue untouched and report op_error.
//   Reset: synchronous; empties the queue. Slot contents are not cleared, the
//   fill count alone marks which slots hold entries.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 fail;
  cell_ctl_t            ctl;
  logic [KEY_WIDTH-1:0] new_key;
  logic [KEY_WIDTH-1:0] slot_key   [DEPTH];
  logic [15:0]          slot_value [DEPTH];
  logic [DEPTH-1:0]     slot_stay;
  logic [DEPTH-1:0]     slot_occ;
  result_t              result_next;

  assign busy   = rst;
  assign accept = start && !busy;
  assign full   = (count == COUNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign fail   = (cmd.operation == OP_INSERT) ? full : empty;

  // Broadcast insert or extract to the row only when it can succeed
  assign ctl.ins = accept && (cmd.operation == OP_INSERT)  && !full;
  assign ctl.ext = accept && (cmd.operation == OP_EXTRACT) && !empty;
  assign new_key = KEY_WIDTH'(cmd.item_key);

  // Build the row of slots
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic                 lstay;
    logic [KEY_WIDTH-1:0] lkey;
    logic [15:0]          lvalue;
    logic [KEY_WIDTH-1:0] rkey;
    logic [15:0]          rvalue;

    assign slot_occ[i] = (COUNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign lstay  = 1'b1;
      assign lkey   = new_key;
      assign lvalue = cmd.item_value;
    end else begin : g_body
      assign lstay  = slot_stay[i-1];
      assign lkey   = slot_key[i-1];
      assign lvalue = slot_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rkey   = slot_key[i];
      assign rvalue = slot_value[i];
    end else begin : g_inner
      assign rkey   = slot_key[i+1];
      assign rvalue = slot_value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (slot_occ[i]),
      .left_stay   (lstay),
      .new_key     (new_key),
      .new_value   (cmd.item_value),
      .left_key    (lkey),
      .left_value  (lvalue),
      .right_key   (rkey),
      .right_value (rvalue),
      .key         (slot_key[i]),
      .value       (slot_value[i]),
      .stay        (slot_stay[i])
    );
  end

  // Advance the fill count and form the result item
  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + COUNT_W'(1);
    end else if (ctl.ext) begin
      count_next = count - COUNT_W'(1);
    end
    result_next             = '0;
    result_next.op_error    = fail;
    result_next.out_valid   = ctl.ext;
    result_next.is_empty    = (count_next == '0);
    result_next.entry_count = 5'(count_next);
    if (ctl.ext) begin
      result_next.out_value = slot_value[0];
      result_next.out_key   = 16'(slot_key[0]);
    end
  end

  // Hold the count and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted command produced no result");

  a_valid_no_err: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.out_valid && result.op_error))
    else $error("result both valid and failed");

  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (result.entry_count == 5'd0)))
    else $error("empty flag disagrees with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(DEPTH))
    else $error("fill count above depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count > COUNT_W'(1)) |-> (slot_key[0] <= slot_key[1]))
    else $error("head slot out of order");

endmodule

>>> test/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue
// Drives insert and extract items with random spacing and keeps its own sorted
// copy of the queue. Each result is checked field by field against that copy,
// including ties, full and empty errors, and the entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int STALL_LIMIT  = 500;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 700;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  // Shadow copy of the queue, head at index 0
  logic [KEY_WIDTH-1:0] sorted_keys [DEPTH];
  logic [15:0]          sorted_vals [DEPTH];
  int                   fill_level;

  // Expected results in arrival order
  result_t pending_results [$];

  int mismatch_count;
  int items_sent;
  int inserts_sent;
  int extracts_sent;
  int full_hits;
  int empty_hits;
  int results_checked;
  int peak_fill;
  int stall_cycles;

  sorted_priority_queue uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Apply one item to the shadow queue and build its expected result
  function automatic result_t apply_queue_op(input cmd_t c);
    result_t r;
    logic [KEY_WIDTH-1:0] k;
    int pos;
    r = '0;
    k = c.item_key[KEY_WIDTH-1:0];
    if (c.operation == OP_INSERT) begin
      if (fill_level >= DEPTH) begin
        r.op_error = 1'b1;
      end else begin
        // new entry goes ahead of equal and larger keys
        pos = 0;
        while (pos < fill_level && sorted_keys[pos] < k) pos++;
        for (int i = fill_level; i > pos; i--) begin
          sorted_keys[i] = sorted_keys[i-1];
          sorted_vals[i] = sorted_vals[i-1];
        end
        sorted_keys[pos] = k;
        sorted_vals[pos] = c.item_value;
        fill_level++;
      end
    end else begin
      if (fill_level == 0) begin
        r.op_error = 1'b1;
      end else begin
        r.out_value = sorted_vals[0];
        r.out_key   = 16'(sorted_keys[0]);
        r.out_valid = 1'b1;
        for (int i = 1; i < fill_level; i++) begin
          sorted_keys[i-1] = sorted_keys[i];
          sorted_vals[i-1] = sorted_vals[i];
        end
        fill_level--;
      end
    end
    r.is_empty    = (fill_level == 0);
    r.entry_count = 5'(fill_level);
    return r;
  endfunction

  // Drive one item and hold it until the queue takes it
  task automatic send_item(input cmd_t c);
    result_t r;
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy || rst);
    if (c.operation == OP_INSERT) begin
      inserts_sent++;
      if (fill_level >= DEPTH) full_hits++;
    end else begin
      extracts_sent++;
      if (fill_level == 0) empty_hits++;
    end
    r = apply_queue_op(c);
    pending_results.push_back(r);
    items_sent++;
    if (fill_level > peak_fill) peak_fill = fill_level;
  endtask

  // Hold start low for a number of cycles
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Stop sending until every expected result has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic cmd_t make_cmd(input logic op, input logic [15:0] val,
                                    input logic [15:0] key);
    cmd_t c;
    c.operation  = op;
    c.item_value = val;
    c.item_key   = key;
    return c;
  endfunction

  // Extract from empty, extreme keys and values, ties in the middle and head
  task automatic test_edge_cases();
    send_item(make_cmd(OP_EXTRACT, 16'hFFFF, 16'hFFFF));
    send_item(make_cmd(OP_INSERT, 16'hFFFF, 16'hFFFF));
    send_item(make_cmd(OP_INSERT, 16'h0000, 16'h0000));
    send_item(make_cmd(OP_INSERT, 16'h1234, 16'h8000));
    send_item(make_cmd(OP_INSERT, 16'hABCD, 16'h8000));
    send_item(make_cmd(OP_INSERT, 16'h5555, 16'h0000));
    send_item(make_cmd(OP_INSERT, 16'hAAAA, 16'hFFFF));
    repeat (7) send_item(make_cmd(OP_EXTRACT, 16'h0000, 16'h0000));
    wait_drained();
  endtask

  // Fill to the limit, overflow, refill one slot, overflow again, then drain past empty
  task automatic test_full_and_drain();
    for (int i = 0; i < DEPTH; i++)
      send_item(make_cmd(OP_INSERT, 16'($urandom), 16'($urandom_range(0, 7))));
    send_item(make_cmd(OP_INSERT, 16'($urandom), 16'($urandom)));
    send_item(make_cmd(OP_EXTRACT, 16'($urandom), 16'($urandom)));
    send_item(make_cmd(OP_INSERT, 16'($urandom), 16'h0000));
    send_item(make_cmd(OP_INSERT, 16'($urandom), 16'h0000));
    for (int i = 0; i < DEPTH + 1; i++) begin
      send_item(make_cmd(OP_EXTRACT, 16'($urandom), 16'($urandom)));
      idle_gap($urandom_range(0, 2));
    end
    wait_drained();
  endtask

  // Random mix in windows with their own insert bias, key spread and idling
  task automatic test_random_traffic(input int count);
    int   insert_pct;
    bit   narrow_keys;
    bit   idling_on;
    logic op;
    logic [15:0] key;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        insert_pct  = $urandom_range(10, 90);
        narrow_keys = ($urandom_range(0, 2) == 0);
        idling_on   = ($urandom_range(0, 2) != 0);
      end
      if (i % 150 == 149) wait_drained();
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
      case ($urandom_range(0, 9))
        0:       key = 16'h0000;
        1:       key = 16'hFFFF;
        default: key = narrow_keys ? 16'($urandom_range(0, 3)) : 16'($urandom);
      endcase
      send_item(make_cmd(op, 16'($urandom), key));
      if (idling_on) idle_gap($urandom_range(0, 12));
    end
    wait_drained();
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: value=%h key=%h valid=%b err=%b empty=%b count=%0d",
                   $realtime, result.out_value, result.out_key, result.out_valid,
                   result.op_error, result.is_empty, result.entry_count);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (result !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: expected value=%h key=%h valid=%b err=%b empty=%b count=%0d",
                     $realtime, want.out_value, want.out_key, want.out_valid,
                     want.op_error, want.is_empty, want.entry_count);
            $display("[%0t]           actual   value=%h key=%h valid=%b err=%b empty=%b count=%0d",
                     $realtime, result.out_value, result.out_key, result.out_valid,
                     result.op_error, result.is_empty, result.entry_count);
          end
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Reset, run each test in turn, then report
  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    cmd             = '0;
    fill_level      = 0;
    mismatch_count  = 0;
    items_sent      = 0;
    inserts_sent    = 0;
    extracts_sent   = 0;
    full_hits       = 0;
    empty_hits      = 0;
    results_checked = 0;
    peak_fill       = 0;
    stall_cycles    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_full_and_drain();
    test_random_traffic(RANDOM_ITEMS);

    repeat (5) @(posedge clk);
    $display("covered %0d items (%0d inserts, %0d extracts), %0d results checked",
             items_sent, inserts_sent, extracts_sent, results_checked);
    $display("full-queue inserts %0d, empty-queue extracts %0d, peak fill %0d, mismatches %0d",
             full_hits, empty_hits, peak_fill, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
